// ----- design/rf3_pkg.sv -----
// Shared types and constants of the 3x3 rank filter.
// Used by rf3_rank and rank_filter_3x3; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rf3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int PIX_W    = 8;
   localparam int COORD_W  = 10;
   localparam int CFG_W    = 11;
   localparam int WIN_SIZE = 9;

   localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH = 11'd512;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [WIN_SIZE-1:0][PIX_W-1:0] window_type;

   typedef enum logic [1:0] {
      RANK_MEDIAN = 2'd0,
      RANK_MAX    = 2'd1,
      RANK_MIN    = 2'd2
   } rank_mode_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH = 1'b0,
      CSR_RANK_MODE   = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// ----- design/rf3_rank.sv -----
// Rank selection over one 3x3 window: median, maximum or minimum.
// Purely combinational; depends on rf3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rf3_rank (
   input  wire rf3_pkg::window_type    window,
   input  wire rf3_pkg::rank_mode_type mode,
   output logic [rf3_pkg::PIX_W-1:0]   result
);

   // Returns {high, middle, low} of three pixels.
   function automatic logic [3*rf3_pkg::PIX_W-1:0] sort3(
      input logic [rf3_pkg::PIX_W-1:0] a,
      input logic [rf3_pkg::PIX_W-1:0] b,
      input logic [rf3_pkg::PIX_W-1:0] c
   );
      logic [rf3_pkg::PIX_W-1:0] lo1, hi1, lo2, hi2, lo3, hi3;
      lo1 = (a < b) ? a : b;
      hi1 = (a < b) ? b : a;
      lo2 = (hi1 < c) ? hi1 : c;
      hi2 = (hi1 < c) ? c : hi1;
      lo3 = (lo1 < lo2) ? lo1 : lo2;
      hi3 = (lo1 < lo2) ? lo2 : lo1;
      return {hi2, hi3, lo3};
   endfunction

   logic [2:0][rf3_pkg::PIX_W-1:0] row_lo, row_mid, row_hi;
   logic [3*rf3_pkg::PIX_W-1:0]    s_lo, s_mid, s_hi, s_med;
   logic [3*rf3_pkg::PIX_W-1:0]    r0, r1, r2;

   // Each window row is sorted first; the extremes and the median then
   // follow from the sorted rows.
   always_comb begin
      r0 = sort3(window[0], window[1], window[2]);
      r1 = sort3(window[3], window[4], window[5]);
      r2 = sort3(window[6], window[7], window[8]);
      row_lo  = {r2[7:0],   r1[7:0],   r0[7:0]};
      row_mid = {r2[15:8],  r1[15:8],  r0[15:8]};
      row_hi  = {r2[23:16], r1[23:16], r0[23:16]};
      s_lo  = sort3(row_lo[0],  row_lo[1],  row_lo[2]);
      s_mid = sort3(row_mid[0], row_mid[1], row_mid[2]);
      s_hi  = sort3(row_hi[0],  row_hi[1],  row_hi[2]);
      // Median of nine: middle of (largest low, middle middle, smallest high).
      s_med = sort3(s_lo[23:16], s_mid[15:8], s_hi[7:0]);
      unique case (mode)
         rf3_pkg::RANK_MAX: result = s_hi[23:16];
         rf3_pkg::RANK_MIN: result = s_lo[7:0];
         default:           result = s_med[15:8];
      endcase
   end

endmodule

`default_nettype wire

// ----- design/rank_filter_3x3.sv -----
// Top level of the 3x3 rank filter: line stores, window, counters and output register.
// Depends on rf3_pkg and rf3_rank.
//
// Usage: 8-bit grayscale pixels enter in raster order on the req_ channel,
// one request per pixel; req_tuser high marks the first pixel of a frame and
// puts it at row 0, column 0. For every pixel (r,c) with r >= 2 and c >= 2 one
// result leaves on the rsp_ channel: the median, maximum or minimum of the
// 3x3 window around (r-1,c-1), with that centre's row and column. Border
// pixels produce no result. The csr_ port sets image_width (index 0) and
// rank_mode (index 1: 0 median, 1 maximum, 2 minimum, 3 median); write it
// only while the filter is idle.
// Throughput is one pixel per clock while the receiver takes results. The accepting
// edge registers the pixel and starts the line-store read; the edge on which
// the pixel leaves the input stage writes the line stores, shifts the window
// and loads the output register, so the result is offered straight after it.
// When the receiver stalls, the result waits in the output register. A pixel
// that produces no result still passes through the input stage, but the next
// pixel that produces one is held there, and further pixels then wait.
// Reset clears the counters, window and valid flags and restores
// image_width to 512 and rank_mode to minimum. The line stores are not
// cleared: every entry is written on a line before the next line reads it.
`timescale 1ns / 1ps
`default_nettype none

module rank_filter_3x3 #(
   parameter int MAX_WIDTH  = rf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rf3_pkg::DEF_MAX_HEIGHT
) (
   input  wire         clock,
   input  wire         reset,
   // Pixel requests.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] pixel
   input  wire  [0:0]  req_tuser,   // [0] frame_start
   // Filter results.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] filtered, [17:8] out_row, [27:18] out_col
   // Configuration writes.
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [10:0] csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PW = rf3_pkg::PIX_W;
   localparam int OW = rf3_pkg::COORD_W;

   // Configuration registers.
   logic [rf3_pkg::CFG_W-1:0] image_width_ff;
   rf3_pkg::rank_mode_type    rank_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= rf3_pkg::RESET_IMAGE_WIDTH;
         rank_mode_ff   <= rf3_pkg::RANK_MIN;
      end else if (csr_we) begin
         unique case (rf3_pkg::csr_index_type'(csr_index))
            rf3_pkg::CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            rf3_pkg::CSR_RANK_MODE:
               rank_mode_ff <= rf3_pkg::rank_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // The width actually used is clamped to at least 3 and at most the line store size.
   logic [31:0]   width_wide;
   logic [EW-1:0] w_eff;

   always_comb begin
      if (image_width_ff < 11'd3) begin
         width_wide = 32'd3;
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_wide = 32'(MAX_WIDTH);
      end else begin
         width_wide = 32'(image_width_ff);
      end
      w_eff = width_wide[EW-1:0];
   end

   // Position of the next pixel.
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] c_cur;
   logic [RW-1:0] r_cur;
   logic [EW:0]   c_next;
   logic          req_accept;

   assign req_accept = req_tvalid && req_tready;

   // A frame start or a line shortened by a new width sends the pixel to
   // column zero; the end of a line advances the row, which saturates.
   always_comb begin
      c_cur = req_tuser[0] ? '0 : col_ff;
      r_cur = req_tuser[0] ? '0 : row_ff;
      if ({1'b0, c_cur} >= (CW + 1)'(w_eff)) begin
         c_cur = '0;
      end
      c_next = (EW + 1)'(c_cur) + (EW + 1)'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         row_in = r_cur;
         if (c_next >= {1'b0, w_eff}) begin
            col_in = '0;
            if (32'(r_cur) < MAX_HEIGHT - 1) begin
               row_in = r_cur + RW'(1);
            end
         end else begin
            col_in = c_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Input stage: the accepted pixel and its position.
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_px_ff;
   logic [CW-1:0] s1_c_ff;
   logic [RW-1:0] s1_r_ff;
   logic          s1_emit_ff;
   logic          s1_adv;
   logic          out_free;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] filtered_ff;
   logic [OW-1:0] out_row_ff;
   logic [OW-1:0] out_col_ff;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_adv      = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff   <= req_tdata;
         s1_c_ff    <= c_cur;
         s1_r_ff    <= r_cur;
         s1_emit_ff <= (32'(r_cur) >= 2) && (32'(c_cur) >= 2);
      end
   end

   // Line stores: store A holds the previous line, store B the one before.
   // Both are read when a pixel is accepted and written when it leaves the
   // input stage.
   logic [PW-1:0] line_a_mem [MAX_WIDTH];
   logic [PW-1:0] line_b_mem [MAX_WIDTH];
   logic [PW-1:0] rd_a_ff, rd_b_ff;
   logic [PW-1:0] top_px, mid_px;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_a_mem[s1_c_ff] <= s1_px_ff;
      end
      if (req_accept) begin
         rd_a_ff <= line_a_mem[c_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_b_mem[s1_c_ff] <= mid_px;
      end
      if (req_accept) begin
         rd_b_ff <= line_b_mem[c_cur];
      end
   end

   // A frame restarting at column zero right after a pixel in column zero
   // reads the entry that is being written in the same cycle; the new data
   // is forwarded instead.
   logic          byp_ff;
   logic [PW-1:0] byp_top_ff, byp_mid_ff;
   logic          byp_hit;

   assign byp_hit = s1_valid_ff && (s1_c_ff == c_cur);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byp_ff     <= byp_hit;
         byp_top_ff <= mid_px;
         byp_mid_ff <= s1_px_ff;
      end
   end

   assign top_px = byp_ff ? byp_top_ff : rd_b_ff;
   assign mid_px = byp_ff ? byp_mid_ff : rd_a_ff;

   // Window columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom.
   logic [5:0][PW-1:0] win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= {s1_px_ff, mid_px, top_px, win_ff[5], win_ff[4], win_ff[3]};
      end
   end

   rf3_pkg::window_type window;
   logic [PW-1:0]       rank_value;

   assign window = {s1_px_ff, win_ff[5], win_ff[2],
                    mid_px,   win_ff[4], win_ff[1],
                    top_px,   win_ff[3], win_ff[0]};

   rf3_rank u_rank (
      .window (window),
      .mode   (rank_mode_ff),
      .result (rank_value)
   );

   // Centre coordinates are one row and one column back, kept to 10 bits.
   logic [31:0] row_m1, col_m1;

   assign row_m1 = 32'(s1_r_ff) - 32'd1;
   assign col_m1 = 32'(s1_c_ff) - 32'd1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_adv && s1_emit_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit_ff) begin
         filtered_ff <= rank_value;
         out_row_ff  <= row_m1[OW-1:0];
         out_col_ff  <= col_m1[OW-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_col_ff, out_row_ff, filtered_ff};

   // A pixel held in the input stage keeps its position.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_c_ff) && $stable(s1_r_ff))
      else $error("input stage lost or changed a held pixel");

   // An accepted pixel always lands inside the effective line.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ({1'b0, c_cur} < (CW + 1)'(w_eff)))
      else $error("pixel column outside the line");

   // The row count never passes its bound.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) <= MAX_HEIGHT - 1)
      else $error("row count above its bound");

   // Forwarding is only needed when a frame restarts at column zero.
   a_byp_cause: assert property (@(posedge clock) disable iff (reset)
      req_accept && byp_hit |-> req_tuser[0] && (c_cur == '0))
      else $error("unexpected line store read of an entry being written");

   // A new result only appears after an emitting pixel left the input stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_emit_ff))
      else $error("result appeared without an emitting pixel");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the 3x3 rank filter: directed table, then random phases.
// Depends on rf3_pkg and rank_filter_3x3; predicts every result with its own window model.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_COLS        = rf3_pkg::DEF_MAX_WIDTH;
   localparam int MAX_ROWS        = rf3_pkg::DEF_MAX_HEIGHT;
   // The input stage and the output register, with some margin.
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_PIXELS   = 1150;
   localparam int DIRECTED_LEN    = 24;
   // The mode code that has no name of its own and acts as the median.
   localparam logic [1:0] RANK_UNUSED = 2'd3;

   typedef logic [rf3_pkg::COORD_W-1:0] coord_type;
   typedef logic [rf3_pkg::CFG_W-1:0]   cfg_word_type;

   typedef struct packed {
      coord_type          col;
      coord_type          row;
      rf3_pkg::pixel_type value;
   } filter_result_type;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;

   // One row of the directed table: either a register write or a pixel request,
   // optionally with its result typed in by hand.
   typedef struct packed {
      step_kind_type          kind;
      rf3_pkg::csr_index_type reg_index;
      cfg_word_type           wdata;
      rf3_pkg::pixel_type     pixel;
      logic                   frame_start;
      logic                   typed;
      filter_result_type      typed_result;
   } directed_step_type;

   typedef enum logic [1:0] {
      ALWAYS_READY, HALF_READY, MOSTLY_STALLED, MOSTLY_READY
   } stall_style_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] pixel
   logic [0:0]  req_tuser = '0;    // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] filtered, [17:8] out_row, [27:18] out_col
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [10:0] csr_wdata = '0;

   rank_filter_3x3 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Filter model. The two line arrays hold the previous two image lines,
   // win_hist the two previous window columns (top, middle, bottom each),
   // and next_col/next_row the position the next pixel will take.
   // ---------------------------------------------------------------------
   rf3_pkg::pixel_type line_above     [MAX_COLS];
   rf3_pkg::pixel_type line_two_above [MAX_COLS];
   logic [5:0][7:0]    win_hist = '0;
   int unsigned        next_col = 0;
   int unsigned        next_row = 0;
   cfg_word_type       width_setting = rf3_pkg::RESET_IMAGE_WIDTH;
   logic [1:0]         mode_setting  = rf3_pkg::RANK_MIN;

   filter_result_type  pending_results [$];
   int unsigned        fail_count = 0;
   int unsigned        burst_left = 0;
   logic               hold_off_armed = 1'b0;
   directed_step_type  directed_steps [DIRECTED_LEN];

   // Widths below three behave as three, widths beyond the line store as its size.
   function automatic int unsigned effective_cols(input cfg_word_type w);
      if (w < 3) return 3;
      if (w > MAX_COLS) return MAX_COLS;
      return 32'(w);
   endfunction

   // Sorts the nine window pixels and picks the element the mode asks for.
   // The unused mode code falls through to the median.
   function automatic rf3_pkg::pixel_type rank_of(input rf3_pkg::window_type nine,
                                                   input logic [1:0] mode);
      rf3_pkg::window_type s;
      rf3_pkg::pixel_type  key;
      int                  j;
      s = nine;
      for (int i = 1; i < rf3_pkg::WIN_SIZE; i++) begin
         key = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > key) begin
            s[j+1] = s[j];
            j--;
         end
         s[j+1] = key;
      end
      case (mode)
         rf3_pkg::RANK_MAX: return s[rf3_pkg::WIN_SIZE-1];
         rf3_pkg::RANK_MIN: return s[0];
         default:           return s[rf3_pkg::WIN_SIZE/2];
      endcase
   endfunction

   // Advances the model by one accepted pixel; returns 1 when a window is complete.
   function automatic logic filter_pixel(input rf3_pkg::pixel_type pix, input logic fs,
                                         output filter_result_type res);
      int unsigned         cols, c, r;
      rf3_pkg::pixel_type  top, mid;
      rf3_pkg::window_type nine;
      logic                produced;
      cols = effective_cols(width_setting);
      res  = '0;
      if (fs) begin
         next_col = 0;
         next_row = 0;
      end
      // A width lowered in the middle of a line ends that line at once.
      if (next_col >= cols) next_col = 0;
      c = next_col;
      r = next_row;
      top = line_two_above[c];
      mid = line_above[c];
      line_two_above[c] = mid;
      line_above[c]     = pix;
      produced = (r >= 2) && (c >= 2);
      if (produced) begin
         // The rank does not depend on the order of the nine pixels.
         nine = {win_hist, top, mid, pix};
         res.value = rank_of(nine, mode_setting);
         res.row   = coord_type'(r - 1);
         res.col   = coord_type'(c - 1);
      end
      win_hist[2:0] = win_hist[5:3];
      win_hist[5:3] = {top, mid, pix};
      if (c + 1 >= cols) begin
         next_col = 0;
         // The row count sticks at its bound, so later centres all report the same row.
         if (next_row < MAX_ROWS - 1) next_row++;
      end else begin
         next_col = c + 1;
      end
      return produced;
   endfunction

   function automatic directed_step_type pix_step(input rf3_pkg::pixel_type p,
                                                  input logic fs);
      directed_step_type s;
      s = '0;
      s.kind        = STEP_PIXEL;
      s.pixel       = p;
      s.frame_start = fs;
      return s;
   endfunction

   function automatic directed_step_type typed_step(input rf3_pkg::pixel_type p,
                                                    input logic fs,
                                                    input rf3_pkg::pixel_type v,
                                                    input coord_type r,
                                                    input coord_type c);
      directed_step_type s;
      s = pix_step(p, fs);
      s.typed              = 1'b1;
      s.typed_result.value = v;
      s.typed_result.row   = r;
      s.typed_result.col   = c;
      return s;
   endfunction

   function automatic directed_step_type write_step(input rf3_pkg::csr_index_type idx,
                                                    input cfg_word_type d);
      directed_step_type s;
      s = '0;
      s.kind      = STEP_WRITE;
      s.reg_index = idx;
      s.wdata     = d;
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Requests come in bursts of random length; between bursts
   // tvalid may drop for a random gap. Within a burst tvalid stays high.
   // ---------------------------------------------------------------------
   task automatic send_pixel(input rf3_pkg::pixel_type pix, input logic fs,
                             input logic typed, input filter_result_type typed_res);
      filter_result_type predicted;
      logic              produced;
      int unsigned       gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      do @(posedge clock); while (!req_tready);
      produced = filter_pixel(pix, fs, predicted);
      if (typed)
         pending_results.push_back(typed_res);
      else if (produced)
         pending_results.push_back(predicted);
   endtask

   // Waits until every expected result has left, then lets the last requests,
   // which may produce nothing, clear the pipeline.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input rf3_pkg::csr_index_type idx,
                                 input cfg_word_type data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == rf3_pkg::CSR_IMAGE_WIDTH)
         width_setting = data;
      else
         mode_setting = data[1:0];
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One random phase: both registers are written in random order, then a run
   // of pixels follows. A wider line than before may only start with a new
   // frame, or the next rows would read line-store entries not yet written; a
   // narrower one may carry on mid-line, which ends the current line early.
   task automatic run_phase(input cfg_word_type width_raw, input logic [1:0] mode,
                            input int unsigned count, input logic new_frame,
                            input logic arm_hold);
      int unsigned        old_cols;
      cfg_word_type       mode_word;
      logic               fs;
      rf3_pkg::pixel_type pix;
      old_cols  = effective_cols(width_setting);
      mode_word = cfg_word_type'($urandom());
      mode_word[1:0] = mode;
      if ($urandom_range(0, 1) == 1) begin
         write_register(rf3_pkg::CSR_IMAGE_WIDTH, width_raw);
         write_register(rf3_pkg::CSR_RANK_MODE, mode_word);
      end else begin
         write_register(rf3_pkg::CSR_RANK_MODE, mode_word);
         write_register(rf3_pkg::CSR_IMAGE_WIDTH, width_raw);
      end
      for (int unsigned n = 0; n < count; n++) begin
         if (n == 0)
            fs = new_frame || (effective_cols(width_setting) > old_cols);
         else
            fs = ($urandom_range(0, 149) == 0);
         case ($urandom_range(0, 9))
            0:       pix = '0;
            1:       pix = '1;
            default: pix = rf3_pkg::pixel_type'($urandom_range(0, 255));
         endcase
         if (arm_hold && n == count / 2) hold_off_armed = 1'b1;
         send_pixel(pix, fs, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock, and a hard limit on the run. The slowest correct run is about
   // 1500 requests, each waiting at most one random gap and a stretch of
   // stalled cycles, plus a few dozen register writes and one hold-off. The
   // limit lies well above what such a run needs.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** rank_filter_3x3: FAILED **");
      $finish;
   end

   // Result side. The receiver changes its stall style in segments of random
   // length; once the main sequence arms it, it holds off for a long stretch
   // so that the filter fills up and refuses further requests.
   initial begin
      int unsigned     seg_len;
      stall_style_type style;
      logic            hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         seg_len = $urandom_range(1, 64);
         style   = stall_style_type'($urandom_range(0, 3));
         repeat (seg_len) begin
            case (style)
               ALWAYS_READY:   rsp_tready <= 1'b1;
               HALF_READY:     rsp_tready <= ($urandom_range(0, 1) == 1);
               MOSTLY_STALLED: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:        rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Each result taken by the receiver is compared with the oldest expectation.
   always @(posedge clock) begin
      filter_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: filtered %0d, out_row %0d, out_col %0d",
                   rsp_tdata[7:0], rsp_tdata[17:8], rsp_tdata[27:18]);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] !== want.value) begin
               $error("filtered: expected %0d, got %0d", want.value, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[17:8] !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_tdata[17:8]);
               fail_count++;
            end
            if (rsp_tdata[27:18] !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_tdata[27:18]);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned  random_sent;
      int unsigned  count;
      int unsigned  guard;
      cfg_word_type width_raw;
      logic         first;

      foreach (line_above[i]) begin
         line_above[i]     = '0;
         line_two_above[i] = '0;
      end

      // Directed table. The width is forced to its floor by writing one, while
      // the mode keeps its reset value, minimum, for the first window. The
      // mode then steps through maximum, the unused code and median. The last
      // three requests restart the frame in the middle of a line and then at
      // once again from column zero. Pixels of 0 and 255 sit in the first
      // window so that the extremes pass through.
      directed_steps = '{
         write_step(rf3_pkg::CSR_IMAGE_WIDTH, 11'd1),
         pix_step(8'd10, 1'b1), pix_step(8'd255, 1'b0), pix_step(8'd30, 1'b0),
         pix_step(8'd40, 1'b0), pix_step(8'd50, 1'b0),  pix_step(8'd60, 1'b0),
         pix_step(8'd70, 1'b0), pix_step(8'd0, 1'b0),
         typed_step(8'd90, 1'b0, 8'd0, 10'd1, 10'd1),
         write_step(rf3_pkg::CSR_RANK_MODE, cfg_word_type'(rf3_pkg::RANK_MAX)),
         pix_step(8'd5, 1'b0), pix_step(8'd6, 1'b0),
         typed_step(8'd7, 1'b0, 8'd90, 10'd2, 10'd1),
         write_step(rf3_pkg::CSR_RANK_MODE, cfg_word_type'(RANK_UNUSED)),
         pix_step(8'd255, 1'b0), pix_step(8'd255, 1'b0), pix_step(8'd255, 1'b0),
         write_step(rf3_pkg::CSR_RANK_MODE, cfg_word_type'(rf3_pkg::RANK_MEDIAN)),
         pix_step(8'd1, 1'b0), pix_step(8'd2, 1'b0), pix_step(8'd3, 1'b1),
         pix_step(8'd128, 1'b1), pix_step(8'd129, 1'b0)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE)
            write_register(directed_steps[i].reg_index, directed_steps[i].wdata);
         else
            send_pixel(directed_steps[i].pixel, directed_steps[i].frame_start,
                       directed_steps[i].typed, directed_steps[i].typed_result);
      end

      // Random phases, mostly on narrow images so that results are frequent.
      // The first one is narrow and long, and arms the receiver's hold-off
      // once the rows are producing results.
      random_sent = 0;
      first = 1'b1;
      while (random_sent < RANDOM_PIXELS) begin
         if (first) begin
            width_raw = cfg_word_type'($urandom_range(3, 8));
            count = 300;
         end else begin
            case ($urandom_range(0, 9))
               0:       width_raw = cfg_word_type'($urandom_range(0, 2));
               1:       width_raw = cfg_word_type'($urandom_range(25, 80));
               default: width_raw = cfg_word_type'($urandom_range(3, 24));
            endcase
            count = $urandom_range(20, 120);
         end
         run_phase(width_raw, 2'($urandom_range(0, 3)), count,
                   $urandom_range(0, 1) == 1, first);
         random_sent += count;
         first = 1'b0;
      end

      // A width beyond the line store is clamped to its size, and rewriting the
      // exact maximum width continues the same line.
      run_phase(11'd2047, 2'($urandom_range(0, 3)), 100, 1'b1, 1'b0);
      run_phase(11'd1024, 2'($urandom_range(0, 3)), 60, 1'b0, 1'b0);

      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end

      if (fail_count == 0)
         $display("** rank_filter_3x3: PASSED **");
      else
         $display("** rank_filter_3x3: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rf3_pkg.sv
design/rf3_rank.sv
design/rank_filter_3x3.sv
tb/tb_top.sv
